// ===== rtl/core/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg: shared types and constants for the rotor mixer
// Field widths, the register index codes, reset values and the internal
// widths of the mixing and thrust-curve datapath.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int CMD_W       = 16;  // Q8.8 command fields
  localparam int CFG_W       = 16;  // widest configuration register
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_MOTORS  = 4;

  // Internal datapath widths (exact, no overflow for any 16-bit input)
  localparam int YK_W        = 32;  // yaw * scale, Q.24
  localparam int FORCE_W     = 33;  // rotor force, Q.24
  localparam int FQ_W        = 21;  // rotor force rounded to Q.12
  localparam int SQ_W        = 40;  // force squared, never negative
  localparam int SQ_LO_W     = 24;
  localparam int SQ_HI_W     = SQ_W - SQ_LO_W;
  localparam int LIN_W       = CFG_W + FQ_W;           // b * f
  localparam int PLO_W       = CFG_W + SQ_LO_W + 1;    // a * low part of f^2
  localparam int PHI_W       = CFG_W + SQ_HI_W + 1;    // a * high part of f^2
  localparam int ACC_W       = 58;                     // curve sum, Q.38
  localparam int CURVE_FRAC  = 38;
  localparam int FORCE_SHIFT = 12;                     // Q.24 -> Q.12
  localparam int LIN_SHIFT   = 12;                     // Q.26 -> Q.38
  localparam int OFF_SHIFT   = 24;                     // Q.14 -> Q.38

  typedef logic signed [CMD_W-1:0] cmd_t;
  typedef logic signed [CFG_W-1:0] coeff_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_YAW_MIX_SCALE  = 3'd0,
    CFG_CURVE_SQUARE   = 3'd1,
    CFG_CURVE_LINEAR   = 3'd2,
    CFG_CURVE_OFFSET   = 3'd3,
    CFG_THRUST_CUTOFF  = 3'd4
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] YAW_MIX_SCALE_RST  = 16'd1638;
  localparam coeff_t           CURVE_SQUARE_RST   = -16'sd513;
  localparam coeff_t           CURVE_LINEAR_RST   = 16'sd5456;
  localparam coeff_t           CURVE_OFFSET_RST   = 16'sd1853;
  localparam coeff_t           THRUST_CUTOFF_RST  = 16'sd256;

endpackage

// ===== rtl/core/qrm_if.sv =====
// ----------------------------------------------------------------------------
// qrm_if: item channels of the rotor mixer
// Command channel (four Q8.8 fields) and duty channel (four duties),
// each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface qrm_in_if import qrm_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t u_thrust;
  cmd_t u_roll;
  cmd_t u_pitch;
  cmd_t u_yaw;

  modport source (output valid, u_thrust, u_roll, u_pitch, u_yaw, input ready);
  modport sink   (input valid, u_thrust, u_roll, u_pitch, u_yaw, output ready);
endinterface

interface qrm_out_if #(parameter int DUTY_W = 13) ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_one;
  logic [DUTY_W-1:0] duty_two;
  logic [DUTY_W-1:0] duty_three;
  logic [DUTY_W-1:0] duty_four;

  modport source (output valid, duty_one, duty_two, duty_three, duty_four, input ready);
  modport sink   (input valid, duty_one, duty_two, duty_three, duty_four, output ready);
endinterface

// ===== rtl/core/quad_rotor_mixer_thrust_curve.sv =====
// ----------------------------------------------------------------------------
// quad_rotor_mixer_thrust_curve: four-rotor mixer with quadratic duty curve
// Mixes thrust, roll, pitch and yaw commands into four rotor forces, maps
// each through a*F^2 + b*F + c0, clamps to a duty of 0..1, zero below cut-off.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake      | contents
//  ---------+-----------+----------------+-----------------------------------
//  in_if    | in        | valid / ready  | u_thrust, u_roll, u_pitch, u_yaw
//  out_if   | out       | valid / ready  | duty_one .. duty_four
//  cfg_*    | in        | cfg_we only    | cfg_idx, cfg_wdata
//
//  Items leave on out_if in the order they were accepted; one
//  item is taken every cycle while the output is drained.
//  Six register stages: yaw scaling, force sums, square and linear products,
//  coefficient products, curve sum, clamp and output register.
//  Each stage holds its item while the one ahead is full and stalled; bubbles
//  close up, so in_if.ready stays high while any stage is empty.
//  rst_n is synchronous: it empties the pipe and restores the register
//  defaults. Write the registers only with the pipe empty.
// ----------------------------------------------------------------------------
module quad_rotor_mixer_thrust_curve import qrm_pkg::*; #(
  parameter int DUTY_FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  qrm_in_if.sink               in_if,
  qrm_out_if.source            out_if
);

  localparam int DUTY_W     = DUTY_FRAC_BITS + 1;
  localparam int DUTY_SHIFT = CURVE_FRAC - DUTY_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (DUTY_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] DUTY_ONE =
    {{(ACC_W-1){1'b0}}, 1'b1} << DUTY_FRAC_BITS;
  localparam logic signed [FORCE_W-1:0] FORCE_HALF =
    {{(FORCE_W-1){1'b0}}, 1'b1} << (FORCE_SHIFT - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] yaw_scale_r;
  coeff_t           sq_coeff_r;
  coeff_t           lin_coeff_r;
  coeff_t           off_coeff_r;
  coeff_t           cutoff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_scale_r <= YAW_MIX_SCALE_RST;
      sq_coeff_r  <= CURVE_SQUARE_RST;
      lin_coeff_r <= CURVE_LINEAR_RST;
      off_coeff_r <= CURVE_OFFSET_RST;
      cutoff_r    <= THRUST_CUTOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_YAW_MIX_SCALE: yaw_scale_r <= cfg_wdata;
        CFG_CURVE_SQUARE:  sq_coeff_r  <= coeff_t'(cfg_wdata);
        CFG_CURVE_LINEAR:  lin_coeff_r <= coeff_t'(cfg_wdata);
        CFG_CURVE_OFFSET:  off_coeff_r <= coeff_t'(cfg_wdata);
        CFG_THRUST_CUTOFF: cutoff_r    <= coeff_t'(cfg_wdata);
        default: ;  // unused indices: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage control: a stage loads when it is empty or the stage ahead loads
  // --------------------------------------------------------------------------
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r;
  logic s1_en, s2_en, s3_en, s4_en, s5_en, s6_en;

  assign s6_en = !s6_vld_r || out_if.ready;
  assign s5_en = !s5_vld_r || s6_en;
  assign s4_en = !s4_vld_r || s5_en;
  assign s3_en = !s3_vld_r || s4_en;
  assign s2_en = !s2_vld_r || s3_en;
  assign s1_en = !s1_vld_r || s2_en;

  assign in_if.ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else begin
      if (s1_en) s1_vld_r <= in_if.valid;
      if (s2_en) s2_vld_r <= s1_vld_r;
      if (s3_en) s3_vld_r <= s2_vld_r;
      if (s4_en) s4_vld_r <= s3_vld_r;
      if (s5_en) s5_vld_r <= s4_vld_r;
      if (s6_en) s6_vld_r <= s5_vld_r;
    end
  end

  // Cut-off flag travels with the item down to the clamp stage
  logic s1_cut_r, s2_cut_r, s3_cut_r, s4_cut_r, s5_cut_r;

  // --------------------------------------------------------------------------
  // Stage 1: scale yaw by k, compare thrust against the cut-off
  // --------------------------------------------------------------------------
  logic signed [YK_W:0]   yk_full;
  cmd_t                   s1_thrust_r, s1_roll_r, s1_pitch_r;
  logic signed [YK_W-1:0] s1_yk_r;

  assign yk_full = in_if.u_yaw * $signed({1'b0, yaw_scale_r});

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_thrust_r <= in_if.u_thrust;
      s1_roll_r   <= in_if.u_roll;
      s1_pitch_r  <= in_if.u_pitch;
      s1_yk_r     <= yk_full[YK_W-1:0];
      s1_cut_r    <= (in_if.u_thrust < cutoff_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: mix into four forces (Q.24) and round half up to Q.12
  // --------------------------------------------------------------------------
  logic signed [FORCE_W-1:0] base_q24, roll_q24, pitch_q24, yaw_q24;
  logic signed [FORCE_W-1:0] force_q24 [NUM_MOTORS];
  logic signed [FORCE_W-1:0] force_rnd [NUM_MOTORS];
  logic signed [FQ_W-1:0]    s2_f_r    [NUM_MOTORS];

  assign base_q24  = FORCE_W'(s1_thrust_r) <<< 14;  // T/4
  assign roll_q24  = FORCE_W'(s1_roll_r)   <<< 15;  // R/2
  assign pitch_q24 = FORCE_W'(s1_pitch_r)  <<< 15;  // P/2
  assign yaw_q24   = FORCE_W'(s1_yk_r);

  assign force_q24[0] = base_q24 - roll_q24  + yaw_q24;
  assign force_q24[1] = base_q24 - pitch_q24 - yaw_q24;
  assign force_q24[2] = base_q24 + roll_q24  + yaw_q24;
  assign force_q24[3] = base_q24 + pitch_q24 - yaw_q24;

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      force_rnd[i] = force_q24[i] + FORCE_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        s2_f_r[i] <= force_rnd[i][FORCE_SHIFT +: FQ_W];
      end
      s2_cut_r <= s1_cut_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: f^2 and b*f
  // --------------------------------------------------------------------------
  logic signed [2*FQ_W-1:0] sq_full  [NUM_MOTORS];
  logic signed [LIN_W-1:0]  lin_full [NUM_MOTORS];
  logic [SQ_W-1:0]          s3_sq_r  [NUM_MOTORS];
  logic signed [LIN_W-1:0]  s3_lin_r [NUM_MOTORS];

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      sq_full[i]  = s2_f_r[i] * s2_f_r[i];
      lin_full[i] = lin_coeff_r * s2_f_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        s3_sq_r[i]  <= sq_full[i][SQ_W-1:0];  // |f| < 2^20, square fits
        s3_lin_r[i] <= lin_full[i];
      end
      s3_cut_r <= s2_cut_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: a*f^2 as two partial products (low 24 bits, high 16 bits)
  // --------------------------------------------------------------------------
  logic signed [PLO_W-1:0] plo_full [NUM_MOTORS];
  logic signed [PHI_W-1:0] phi_full [NUM_MOTORS];
  logic signed [PLO_W-1:0] s4_plo_r [NUM_MOTORS];
  logic signed [PHI_W-1:0] s4_phi_r [NUM_MOTORS];
  logic signed [LIN_W-1:0] s4_lin_r [NUM_MOTORS];

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      plo_full[i] = sq_coeff_r * $signed({1'b0, s3_sq_r[i][SQ_LO_W-1:0]});
      phi_full[i] = sq_coeff_r * $signed({1'b0, s3_sq_r[i][SQ_W-1:SQ_LO_W]});
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        s4_plo_r[i] <= plo_full[i];
        s4_phi_r[i] <= phi_full[i];
        s4_lin_r[i] <= s3_lin_r[i];
      end
      s4_cut_r <= s3_cut_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: curve sum in Q.38 with the rounding half already added
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] off_term;
  logic signed [ACC_W-1:0] acc_nxt  [NUM_MOTORS];
  logic signed [ACC_W-1:0] s5_acc_r [NUM_MOTORS];

  assign off_term = (ACC_W'(off_coeff_r) <<< OFF_SHIFT) + ROUND_HALF;

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      acc_nxt[i] = (ACC_W'(s4_phi_r[i]) <<< SQ_LO_W)
                 + ACC_W'(s4_plo_r[i])
                 + (ACC_W'(s4_lin_r[i]) <<< LIN_SHIFT)
                 + off_term;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_en) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        s5_acc_r[i] <= acc_nxt[i];
      end
      s5_cut_r <= s4_cut_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: floor to Q.DUTY_FRAC_BITS, clamp to 0..1, zero below cut-off
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] duty_full [NUM_MOTORS];
  logic [DUTY_W-1:0]       duty_nxt  [NUM_MOTORS];
  logic [DUTY_W-1:0]       s6_duty_r [NUM_MOTORS];

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      duty_full[i] = s5_acc_r[i] >>> DUTY_SHIFT;
      if (s5_cut_r || duty_full[i][ACC_W-1]) begin
        duty_nxt[i] = '0;
      end else if (duty_full[i] > DUTY_ONE) begin
        duty_nxt[i] = DUTY_ONE[DUTY_W-1:0];
      end else begin
        duty_nxt[i] = duty_full[i][DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s6_en) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        s6_duty_r[i] <= duty_nxt[i];
      end
    end
  end

  assign out_if.valid      = s6_vld_r;
  assign out_if.duty_one   = s6_duty_r[0];
  assign out_if.duty_two   = s6_duty_r[1];
  assign out_if.duty_three = s6_duty_r[2];
  assign out_if.duty_four  = s6_duty_r[3];

endmodule

// ===== verif/quad_rotor_mixer_thrust_curve_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quad_rotor_mixer_thrust_curve_tb: self-checking bench for the rotor mixer
// Drives control vectors through the command channel and predicts the four
// duties of each one in exact 64-bit integer arithmetic. A small scoreboard
// compares every duty item, motor by motor. The run steps through several
// register settings, the extremes among them, with random idling on both
// channels.
// ----------------------------------------------------------------------------
module quad_rotor_mixer_thrust_curve_tb import qrm_pkg::*; ();

  localparam int DUTY_FRAC_BITS   = 12;
  localparam int DUTY_W           = DUTY_FRAC_BITS + 1;
  localparam int DUTY_SHIFT       = CURVE_FRAC - DUTY_FRAC_BITS;  // Q.38 -> Q.12
  localparam int PIPE_DEPTH       = 6;
  localparam int NUM_PHASES       = 7;
  localparam int RANDOM_PER_PHASE = 72;
  localparam int NUM_DIRECTED     = 21;
  localparam int MAX_IDLE         = 17;
  localparam int RUN_LIMIT_NS     = 5_000_000;

  typedef struct {
    cmd_t thrust;
    cmd_t roll;
    cmd_t pitch;
    cmd_t yaw;
  } command_t;

  typedef struct {
    logic [DUTY_W-1:0] duty [NUM_MOTORS];
  } duties_t;

  typedef struct {
    logic [CFG_W-1:0] yaw_scale;
    coeff_t           square;
    coeff_t           linear;
    coeff_t           offset;
    coeff_t           cutoff;
  } curve_setting_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the duties of each accepted command and holds them
  // until the matching duty item leaves the block.
  // --------------------------------------------------------------------------
  class mixer_scoreboard;
    curve_setting_t setting;
    duties_t        expected_duties [$];
    int             mismatches;

    function new();
      setting.yaw_scale = YAW_MIX_SCALE_RST;
      setting.square    = CURVE_SQUARE_RST;
      setting.linear    = CURVE_LINEAR_RST;
      setting.offset    = CURVE_OFFSET_RST;
      setting.cutoff    = THRUST_CUTOFF_RST;
      mismatches        = 0;
    endfunction

    // Round a Q.24 force to Q.12, run it through the curve, clamp to 0..1.
    function logic [DUTY_W-1:0] curve_duty(longint force_q24);
      longint f;
      longint acc;
      longint d;
      f   = (force_q24 + (longint'(1) << (FORCE_SHIFT - 1))) >>> FORCE_SHIFT;
      acc = longint'(setting.square) * f * f
          + (longint'(setting.linear) * f <<< LIN_SHIFT)
          + (longint'(setting.offset) <<< OFF_SHIFT);
      d   = (acc + (longint'(1) << (DUTY_SHIFT - 1))) >>> DUTY_SHIFT;
      if (d < 0) d = 0;
      if (d > (longint'(1) << DUTY_FRAC_BITS)) d = longint'(1) << DUTY_FRAC_BITS;
      return d[DUTY_W-1:0];
    endfunction

    function duties_t mix_command(command_t c);
      duties_t r;
      longint  base;
      longint  roll_half;
      longint  pitch_half;
      longint  yaw_part;
      base       = longint'(c.thrust) * 16384;   // T/4 in Q.24
      roll_half  = longint'(c.roll) * 32768;     // R/2 in Q.24
      pitch_half = longint'(c.pitch) * 32768;
      yaw_part   = longint'(c.yaw) * longint'(setting.yaw_scale);
      if (longint'(c.thrust) < longint'(setting.cutoff)) begin
        foreach (r.duty[m]) r.duty[m] = '0;
      end else begin
        r.duty[0] = curve_duty(base - roll_half + yaw_part);
        r.duty[1] = curve_duty(base - pitch_half - yaw_part);
        r.duty[2] = curve_duty(base + roll_half + yaw_part);
        r.duty[3] = curve_duty(base + pitch_half - yaw_part);
      end
      return r;
    endfunction

    function void note_command(command_t c);
      expected_duties.push_back(mix_command(c));
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    task check_duties(duties_t got);
      duties_t want;
      if (expected_duties.size() == 0) begin
        report_mismatch("duty item with no command outstanding");
      end else begin
        want = expected_duties.pop_front();
        foreach (want.duty[m]) begin
          if (got.duty[m] !== want.duty[m])
            report_mismatch($sformatf("motor %0d duty %0d, predicted %0d",
                                      m + 1, got.duty[m], want.duty[m]));
        end
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  qrm_in_if                     in_if ();
  qrm_out_if #(.DUTY_W(DUTY_W)) out_if ();

  quad_rotor_mixer_thrust_curve #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  mixer_scoreboard sb = new();

  // Idling switches, flipped now and then so that back-to-back stretches
  // alternate with gappy ones on each channel.
  bit send_idle;
  bit drain_idle;

  always #10 clk = ~clk;

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.u_thrust = '0;
    in_if.u_roll  = '0;
    in_if.u_pitch = '0;
    in_if.u_yaw   = '0;
    out_if.ready  = 1'b0;
    send_idle     = 1'b0;
    drain_idle    = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  function automatic int draw_idle(bit enabled);
    return enabled ? int'($urandom_range(0, MAX_IDLE)) : 0;
  endfunction

  // Uniform signed value in lo..hi.
  function automatic cmd_t pick(int lo, int hi);
    return cmd_t'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // --------------------------------------------------------------------------
  // Duty side: stall for a drawn number of cycles, then take one item and
  // hand it to the scoreboard. Ready is never dropped and raised in one step.
  // --------------------------------------------------------------------------
  initial begin
    duties_t got;
    int      stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_idle(drain_idle);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.duty[0] = out_if.duty_one;
      got.duty[1] = out_if.duty_two;
      got.duty[2] = out_if.duty_three;
      got.duty[3] = out_if.duty_four;
      sb.check_duties(got);
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Present one command after an optional gap and hold it until taken. Valid
  // stays high on return, so a following command with no gap goes straight on.
  task send_command(command_t c);
    int gap;
    gap = draw_idle(send_idle);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.u_thrust <= c.thrust;
    in_if.u_roll   <= c.roll;
    in_if.u_pitch  <= c.pitch;
    in_if.u_yaw    <= c.yaw;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_command(c);
  endtask

  // Drop valid and hold off until every predicted duty item has come back.
  // Always waits on a clock edge before returning, so the next drive lands in a new step.
  task wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_duties.size() != 0);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Load a whole setting while the pipe is empty. Optionally scribble on the
  // unused register indices as well; the block must ignore those writes.
  task program_regs(curve_setting_t s, bit poke_unused);
    write_reg(CFG_YAW_MIX_SCALE, s.yaw_scale);
    write_reg(CFG_CURVE_SQUARE, s.square);
    write_reg(CFG_CURVE_LINEAR, s.linear);
    write_reg(CFG_CURVE_OFFSET, s.offset);
    write_reg(CFG_THRUST_CUTOFF, s.cutoff);
    if (poke_unused) begin
      for (int k = CFG_THRUST_CUTOFF + 1; k < (1 << CFG_IDX_W); k++)
        write_reg(k[CFG_IDX_W-1:0], CFG_W'($urandom));
    end
    cfg_we <= 1'b0;
    sb.setting = s;
  endtask

  // Mostly plausible flight commands, some straddling the cutoff, the rest
  // raw 16-bit noise so that every input bit toggles.
  function automatic command_t random_command();
    command_t c;
    int       t;
    case ($urandom_range(0, 9)) inside
      0, 1: begin
        c.thrust = cmd_t'($urandom);
        c.roll   = cmd_t'($urandom);
        c.pitch  = cmd_t'($urandom);
        c.yaw    = cmd_t'($urandom);
      end
      2: begin
        t = int'(sb.setting.cutoff) + int'($urandom_range(0, 6)) - 3;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        c.thrust = cmd_t'(t);
        c.roll   = pick(-3000, 3000);
        c.pitch  = pick(-3000, 3000);
        c.yaw    = pick(-32768, 32767);
      end
      default: begin
        c.thrust = pick(0, 12000);
        c.roll   = pick(-3000, 3000);
        c.pitch  = pick(-3000, 3000);
        c.yaw    = pick(-32768, 32767);
      end
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  // Field extremes, the cutoff boundary at its reset value, forces that
  // drive the curve negative and ones near its peak.
  int directed [NUM_DIRECTED][4] = '{
    '{     0,      0,      0,      0},   // zero thrust, below cutoff
    '{   255,      0,      0,      0},   // one below cutoff
    '{   256,      0,      0,      0},   // exactly at cutoff
    '{    -1,      0,      0,      0},
    '{ 32767,      0,      0,      0},
    '{-32768,      0,      0,      0},
    '{ 32767,  32767,  32767,  32767},
    '{ 32767, -32768, -32768, -32768},
    '{ 32767, -32768,  32767, -32768},
    '{ 32767,  32767, -32768,  32767},
    '{ 32767,     -1,     -1,     -1},
    '{  5000,      0,      0,      0},
    '{  5000,   1000,  -1000,  20000},
    '{  5000,  -1000,   1000, -20000},
    '{  8000,   3000,   3000,      0},
    '{  1000,  -2048,   2048,  32767},   // a negative force, its duty clamps to zero
    '{ 10240,      0,      0,      0},   // past the curve's peak, duty falling
    '{ 20000,      0,      0,      0},   // past the peak, curve turns down
    '{   256, -32768,  32767, -32768},
    '{   300,      0,      0, -32768},
    '{  4096,    512,   -512,   8192}
  };

  curve_setting_t settings [NUM_PHASES];

  initial begin
    command_t c;

    // Phase 0 runs on the reset defaults; the rest are written in turn.
    settings[0] = sb.setting;
    settings[1] = '{16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sd32768};
    settings[2] = '{16'h0000, -16'sd32768, -16'sd32768, -16'sd32768, 16'sh7FFF};
    // Unity slope, no offset: duty follows force and saturates above 1 N.
    settings[3] = '{16'hFFFF, 16'sd0, 16'sd16384, 16'sd0, 16'sd0};
    settings[4] = '{CFG_W'($urandom), pick(-2000, 0), pick(0, 16000),
                    pick(-4000, 4000), pick(-2000, 4000)};
    settings[5] = '{CFG_W'($urandom), cmd_t'($urandom), cmd_t'($urandom),
                    cmd_t'($urandom), pick(-2000, 4000)};
    settings[6] = sb.setting;   // defaults again, written this time

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Registers move only with the pipe empty.
      wait_drained();
      if (ph > 0) program_regs(settings[ph], ph == NUM_PHASES - 1);
      send_idle  = (ph % 3) != 1;
      drain_idle = (ph % 2) == 0;

      if (ph == 0) begin
        foreach (directed[d]) begin
          c.thrust = cmd_t'(directed[d][0]);
          c.roll   = cmd_t'(directed[d][1]);
          c.pitch  = cmd_t'(directed[d][2]);
          c.yaw    = cmd_t'(directed[d][3]);
          send_command(c);
        end
      end

      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (i % 24 == 23) begin
          send_idle  = $urandom_range(0, 2) != 0;
          drain_idle = $urandom_range(0, 2) != 0;
        end
        // Mid-stream pause: let the pipe run dry, then resume.
        if (ph == 4 && i == RANDOM_PER_PHASE / 2) wait_drained();
        send_command(random_command());
      end
    end

    wait_drained();
    repeat (4 * PIPE_DEPTH) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_duties.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
